// ===== src/dpws_pkg.sv =====
// constants and shared types for the dual potentiometer wiper sequencer
// no dependencies
package dpws_pkg;

    localparam int unsigned POS_W = 7;
    localparam int unsigned PIN_W = 8;

    // homing run length and top wiper position
    localparam logic [POS_W-1:0] HOME_PULSES  = 7'd100;
    localparam logic [POS_W-1:0] TOP_POSITION = 7'd99;

    // gpio bit masks
    localparam logic [PIN_W-1:0] PIN_CSF = 8'h80;
    localparam logic [PIN_W-1:0] PIN_CSC = 8'h10;
    localparam logic [PIN_W-1:0] PIN_UD  = 8'h40;
    localparam logic [PIN_W-1:0] PIN_INC = 8'h20;

    // opcodes
    localparam logic OP_MOVE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // one input item
    typedef struct packed {
        logic             opcode;
        logic [POS_W-1:0] coarse_target;
        logic [POS_W-1:0] fine_target;
        logic [PIN_W-1:0] pins_now;
    } item_t;

    // one result item with its valid flag
    typedef struct packed {
        logic             emit;
        logic [PIN_W-1:0] pin_word;
        logic             last_word;
    } result_t;

endpackage

// ===== src/dpws_seq.sv =====
// sequencer state and per-item next-state logic for both potentiometers
// depends on dpws_pkg
module dpws_seq
    import dpws_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  item_t   item,
    output result_t result
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_PRE0, PH_PRE1, PH_PRE2,
        PH_CH_OPEN, PH_CH_PULSE, PH_FH_OPEN, PH_FH_PULSE, PH_HOME_CLOSE,
        PH_CS_OPEN, PH_CS_PULSE, PH_FS_OPEN, PH_FS_PULSE, PH_STEP_CLOSE,
        PH_FINAL
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] coarse_pos_reg, coarse_pos_next;
    logic [POS_W-1:0] fine_pos_reg, fine_pos_next;
    logic             coarse_known_reg, coarse_known_next;
    logic             fine_known_reg, fine_known_next;
    logic [POS_W-1:0] coarse_goal_reg, coarse_goal_next;
    logic [POS_W-1:0] fine_goal_reg, fine_goal_next;
    logic [PIN_W-1:0] base_pins_reg, base_pins_next;
    logic [POS_W-1:0] pulse_count_reg, pulse_count_next;
    logic             half_pulse_reg, half_pulse_next;

    logic [POS_W-1:0] cnt_inc;
    logic             coarse_up, fine_up;
    logic [POS_W-1:0] coarse_stepped, fine_stepped;
    phase_t           run_phase;
    logic [PIN_W-1:0] desel;

    assign desel   = PIN_CSF | PIN_CSC;
    assign cnt_inc = pulse_count_reg + 7'd1;

    // step direction and the moved position of each wiper
    assign coarse_up      = coarse_goal_reg > coarse_pos_reg;
    assign fine_up        = fine_goal_reg > fine_pos_reg;
    assign coarse_stepped = coarse_up ? coarse_pos_reg + 7'd1 : coarse_pos_reg - 7'd1;
    assign fine_stepped   = fine_up ? fine_pos_reg + 7'd1 : fine_pos_reg - 7'd1;

    // choice of the next run after a preamble or closing word
    always_comb
    begin
        if (!coarse_known_reg)
            run_phase = PH_CH_OPEN;
        else if (!fine_known_reg)
            run_phase = PH_FH_OPEN;
        else if (coarse_pos_reg != coarse_goal_reg)
            run_phase = PH_CS_OPEN;
        else if (fine_pos_reg != fine_goal_reg)
            run_phase = PH_FS_OPEN;
        else
            run_phase = PH_FINAL;
    end

    // next state and pin word for one item
    always_comb
    begin
        phase_next        = phase_reg;
        coarse_pos_next   = coarse_pos_reg;
        fine_pos_next     = fine_pos_reg;
        coarse_known_next = coarse_known_reg;
        fine_known_next   = fine_known_reg;
        coarse_goal_next  = coarse_goal_reg;
        fine_goal_next    = fine_goal_reg;
        base_pins_next    = base_pins_reg;
        pulse_count_next  = pulse_count_reg;
        half_pulse_next   = half_pulse_reg;
        result            = '0;

        if (item.opcode == OP_MOVE) begin
            // command is taken only while idle
            if (phase_reg == PH_IDLE) begin
                coarse_goal_next = (item.coarse_target > TOP_POSITION) ?
                                   TOP_POSITION : item.coarse_target;
                fine_goal_next   = (item.fine_target > TOP_POSITION) ?
                                   TOP_POSITION : item.fine_target;
                base_pins_next   = item.pins_now;
                phase_next       = PH_PRE0;
            end
        end else begin
            result.emit = 1'b1;
            case (phase_reg)
                PH_PRE0:
                begin
                    result.pin_word = base_pins_reg;
                    phase_next      = PH_PRE1;
                end
                PH_PRE1:
                begin
                    result.pin_word = base_pins_reg | PIN_INC;
                    phase_next      = PH_PRE2;
                end
                PH_PRE2, PH_HOME_CLOSE, PH_STEP_CLOSE:
                begin
                    if (phase_reg == PH_PRE2)
                        result.pin_word = base_pins_reg | PIN_INC | desel;
                    else if (phase_reg == PH_HOME_CLOSE)
                        result.pin_word = desel | PIN_UD;
                    else
                        result.pin_word = desel | PIN_INC;
                    phase_next       = run_phase;
                    pulse_count_next = '0;
                    half_pulse_next  = 1'b0;
                end
                PH_CH_OPEN, PH_FH_OPEN:
                begin
                    result.pin_word = desel | PIN_INC;
                    phase_next      = (phase_reg == PH_CH_OPEN) ? PH_CH_PULSE : PH_FH_PULSE;
                end
                PH_CH_PULSE, PH_FH_PULSE:
                begin
                    // homing pulse halves, always upward
                    if (!half_pulse_reg) begin
                        result.pin_word = ((phase_reg == PH_CH_PULSE) ? PIN_CSF : PIN_CSC)
                                          | PIN_INC | PIN_UD;
                        half_pulse_next = 1'b1;
                    end else begin
                        result.pin_word = ((phase_reg == PH_CH_PULSE) ? PIN_CSF : PIN_CSC)
                                          | PIN_UD;
                        half_pulse_next  = 1'b0;
                        pulse_count_next = cnt_inc;
                        if (cnt_inc >= HOME_PULSES) begin
                            if (phase_reg == PH_CH_PULSE) begin
                                coarse_known_next = 1'b1;
                                coarse_pos_next   = TOP_POSITION;
                            end else begin
                                fine_known_next = 1'b1;
                                fine_pos_next   = TOP_POSITION;
                            end
                            phase_next = PH_HOME_CLOSE;
                        end
                    end
                end
                PH_CS_OPEN:
                begin
                    result.pin_word = PIN_CSF | PIN_INC;
                    phase_next      = PH_CS_PULSE;
                end
                PH_FS_OPEN:
                begin
                    result.pin_word = PIN_CSC | PIN_INC;
                    phase_next      = PH_FS_PULSE;
                end
                PH_CS_PULSE:
                begin
                    // coarse: increment high on the first half, low on the second
                    result.pin_word = PIN_CSF | (coarse_up ? PIN_UD : '0)
                                      | (half_pulse_reg ? '0 : PIN_INC);
                    half_pulse_next = !half_pulse_reg;
                    if (half_pulse_reg) begin
                        coarse_pos_next = coarse_stepped;
                        if (coarse_stepped == coarse_goal_reg)
                            phase_next = PH_STEP_CLOSE;
                    end
                end
                PH_FS_PULSE:
                begin
                    // fine: reverse phase order
                    result.pin_word = PIN_CSC | (fine_up ? PIN_UD : '0)
                                      | (half_pulse_reg ? PIN_INC : '0);
                    half_pulse_next = !half_pulse_reg;
                    if (half_pulse_reg) begin
                        fine_pos_next = fine_stepped;
                        if (fine_stepped == fine_goal_reg)
                            phase_next = PH_STEP_CLOSE;
                    end
                end
                PH_FINAL:
                begin
                    result.pin_word  = desel | PIN_INC;
                    result.last_word = 1'b1;
                    phase_next       = PH_IDLE;
                end
                default:
                begin
                    // tick while idle, or a meaningless phase code
                    result.emit = 1'b0;
                    phase_next  = PH_IDLE;
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PH_IDLE;
            coarse_pos_reg   <= '0;
            fine_pos_reg     <= '0;
            coarse_known_reg <= 1'b0;
            fine_known_reg   <= 1'b0;
            coarse_goal_reg  <= '0;
            fine_goal_reg    <= '0;
            base_pins_reg    <= '0;
            pulse_count_reg  <= '0;
            half_pulse_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            coarse_pos_reg   <= coarse_pos_next;
            fine_pos_reg     <= fine_pos_next;
            coarse_known_reg <= coarse_known_next;
            fine_known_reg   <= fine_known_next;
            coarse_goal_reg  <= coarse_goal_next;
            fine_goal_reg    <= fine_goal_next;
            base_pins_reg    <= base_pins_next;
            pulse_count_reg  <= pulse_count_next;
            half_pulse_reg   <= half_pulse_next;
        end
    end

endmodule

// ===== src/dual_pot_wiper_sequencer.sv =====
// dual up/down potentiometer wiper sequencer, top level
// input register, dpws_seq sequencer and result register; depends on dpws_pkg
//
// usage: each input transfer is either a move command (opcode 0) carrying
// both target positions and the current gpio byte, or a tick (opcode 1).
// a tick yields one pin word on the output channel; a command, a tick while
// idle and a command that arrives while a sequence runs yield nothing.
// a sequence is three preamble words, homing runs for wipers of unknown
// position, step runs towards the targets and a final word flagged by
// last_word.
// a result passes the input register, the combinational sequencer step and
// then the result register. throughput: one item per cycle while the
// receiver keeps out_ready high.
// reset clears the sequencer to idle with both wiper positions unknown and
// empties both registers. when the receiver holds out_ready low the result
// register holds its word and the input register may still fill; in_ready
// drops only once both are occupied.
module dual_pot_wiper_sequencer
    import dpws_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             opcode,
    input  logic [POS_W-1:0] coarse_target,
    input  logic [POS_W-1:0] fine_target,
    input  logic [PIN_W-1:0] pins_now,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIN_W-1:0] pin_word,
    output logic             last_word
);

    logic             in_valid_reg;
    item_t            item_reg;
    logic             out_valid_reg;
    logic [PIN_W-1:0] pin_word_reg;
    logic             last_word_reg;
    logic             advance;
    logic             fire;
    result_t          result;

    // pipeline control
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    dpws_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (fire),
        .item    (item_reg),
        .result  (result)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= fire && result.emit;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            item_reg.opcode        <= opcode;
            item_reg.coarse_target <= coarse_target;
            item_reg.fine_target   <= fine_target;
            item_reg.pins_now      <= pins_now;
        end
        if (fire && result.emit) begin
            pin_word_reg  <= result.pin_word;
            last_word_reg <= result.last_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign pin_word  = pin_word_reg;
    assign last_word = last_word_reg;

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for dual_pot_wiper_sequencer: directed table, then random moves
// predicts each pin word in-line or takes the typed word of a directed row; depends on dpws_pkg and the sequencer rtl
`timescale 1ns / 1ps

module tb
    import dpws_pkg::*;
;

    localparam int RANDOM_ITEMS = 100;
    localparam int STEADY_SPAN  = 48;
    localparam int DIR_ROWS     = 12;

    // phases of the move sequence as the predictor tracks them
    typedef enum logic [3:0] {
        SQ_IDLE, SQ_PRE0, SQ_PRE1, SQ_PRE2,
        SQ_CH_OPEN, SQ_CH_PULSE, SQ_FH_OPEN, SQ_FH_PULSE, SQ_HOME_CLOSE,
        SQ_CS_OPEN, SQ_CS_PULSE, SQ_FS_OPEN, SQ_FS_PULSE, SQ_STEP_CLOSE,
        SQ_FINAL
    } seq_phase_t;

    // one row of the directed table: stimulus, whether the word is typed in, typed word
    typedef struct packed {
        item_t   stim;
        logic    typed;
        result_t want;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             opcode;
    logic [POS_W-1:0] coarse_target;
    logic [POS_W-1:0] fine_target;
    logic [PIN_W-1:0] pins_now;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [PIN_W-1:0] pin_word;
    logic             last_word;

    // predicted wiper and sequence state
    logic [POS_W-1:0] coarse_pos, fine_pos, coarse_goal, fine_goal, pulse_cnt;
    logic             coarse_known, fine_known, half_done;
    logic [PIN_W-1:0] base_pins;
    seq_phase_t       seq_phase;

    result_t expected_words [$];
    int      mismatches = 0;
    int      ready_hold = 0;
    bit      steady     = 1'b0;

    dir_row_t dir_table [0:DIR_ROWS-1] = '{
        {OP_TICK, 7'd127, 7'd0,   8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
        {OP_MOVE, 7'd127, 7'd127, 8'h0F, 1'b1, 1'b0, 8'h00, 1'b0},
        {OP_MOVE, 7'd0,   7'd0,   8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
        {OP_TICK, 7'd0,   7'd0,   8'h00, 1'b1, 1'b1, 8'h0F, 1'b0},
        {OP_TICK, 7'd0,   7'd0,   8'h00, 1'b1, 1'b1, 8'h0F | PIN_INC, 1'b0},
        {OP_TICK, 7'd0,   7'd0,   8'h00, 1'b1, 1'b1,
            8'h0F | PIN_INC | PIN_CSF | PIN_CSC, 1'b0},
        {OP_TICK, 7'd99,  7'd99,  8'hAA, 1'b1, 1'b1, PIN_CSF | PIN_CSC | PIN_INC, 1'b0},
        {OP_TICK, 7'd1,   7'd64,  8'h55, 1'b1, 1'b1, PIN_CSF | PIN_INC | PIN_UD, 1'b0},
        {OP_TICK, 7'd64,  7'd1,   8'hAA, 1'b1, 1'b1, PIN_CSF | PIN_UD, 1'b0},
        {OP_MOVE, 7'd64,  7'd1,   8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
        {OP_TICK, 7'd127, 7'd127, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        {OP_TICK, 7'd0,   7'd127, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0}
    };

    dual_pot_wiper_sequencer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .coarse_target (coarse_target),
        .fine_target   (fine_target),
        .pins_now      (pins_now),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pin_word      (pin_word),
        .last_word     (last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // start a new run and choose which one comes next
    function automatic seq_phase_t pick_next_run();
        pulse_cnt = '0;
        half_done = 1'b0;
        if (!coarse_known)
            return SQ_CH_OPEN;
        if (!fine_known)
            return SQ_FH_OPEN;
        if (coarse_pos != coarse_goal)
            return SQ_CS_OPEN;
        if (fine_pos != fine_goal)
            return SQ_FS_OPEN;
        return SQ_FINAL;
    endfunction

    // one half of a homing pulse, wiper lands at the top after the last one
    task automatic homing_half(input logic [PIN_W-1:0] sel, input bit is_coarse,
                               output logic [PIN_W-1:0] w);
        if (!half_done)
        begin
            w = sel | PIN_INC | PIN_UD;
            half_done = 1'b1;
        end
        else
        begin
            w = sel | PIN_UD;
            half_done = 1'b0;
            pulse_cnt = pulse_cnt + 1'b1;
            if (pulse_cnt >= HOME_PULSES)
            begin
                if (is_coarse)
                begin
                    coarse_known = 1'b1;
                    coarse_pos = TOP_POSITION;
                end
                else
                begin
                    fine_known = 1'b1;
                    fine_pos = TOP_POSITION;
                end
                seq_phase = SQ_HOME_CLOSE;
            end
        end
    endtask

    // one half of a step pulse, position moves on the second half
    task automatic stepping_half(inout logic [POS_W-1:0] pos,
                                 input logic [POS_W-1:0] goal,
                                 input logic [PIN_W-1:0] sel, input bit inc_first,
                                 output logic [PIN_W-1:0] w);
        logic up;
        logic inc;
        up = goal > pos;
        inc = half_done ? !inc_first : inc_first;
        w = sel | (up ? PIN_UD : '0) | (inc ? PIN_INC : '0);
        if (!half_done)
            half_done = 1'b1;
        else
        begin
            half_done = 1'b0;
            pos = up ? pos + 1'b1 : pos - 1'b1;
            if (pos == goal)
                seq_phase = SQ_STEP_CLOSE;
        end
    endtask

    // pin word caused by one input transfer, if any
    task automatic predict_pin_word(input item_t it, output result_t res);
        logic [PIN_W-1:0] desel;
        logic [PIN_W-1:0] w;
        desel = PIN_CSF | PIN_CSC;
        w = '0;
        res = '0;
        if (it.opcode == OP_MOVE)
        begin
            // commands latch only when idle and never yield a word
            if (seq_phase == SQ_IDLE)
            begin
                coarse_goal = (it.coarse_target > TOP_POSITION) ? TOP_POSITION
                                                                : it.coarse_target;
                fine_goal = (it.fine_target > TOP_POSITION) ? TOP_POSITION
                                                            : it.fine_target;
                base_pins = it.pins_now;
                seq_phase = SQ_PRE0;
            end
        end
        else
        begin
            res.emit = 1'b1;
            case (seq_phase)
                SQ_PRE0:
                begin
                    w = base_pins;
                    seq_phase = SQ_PRE1;
                end
                SQ_PRE1:
                begin
                    w = base_pins | PIN_INC;
                    seq_phase = SQ_PRE2;
                end
                SQ_PRE2:
                begin
                    w = base_pins | PIN_INC | desel;
                    seq_phase = pick_next_run();
                end
                SQ_CH_OPEN:
                begin
                    w = desel | PIN_INC;
                    seq_phase = SQ_CH_PULSE;
                end
                SQ_CH_PULSE:
                    homing_half(PIN_CSF, 1'b1, w);
                SQ_FH_OPEN:
                begin
                    w = desel | PIN_INC;
                    seq_phase = SQ_FH_PULSE;
                end
                SQ_FH_PULSE:
                    homing_half(PIN_CSC, 1'b0, w);
                SQ_HOME_CLOSE:
                begin
                    w = desel | PIN_UD;
                    seq_phase = pick_next_run();
                end
                SQ_CS_OPEN:
                begin
                    w = PIN_CSF | PIN_INC;
                    seq_phase = SQ_CS_PULSE;
                end
                SQ_CS_PULSE:
                    stepping_half(coarse_pos, coarse_goal, PIN_CSF, 1'b1, w);
                SQ_FS_OPEN:
                begin
                    w = PIN_CSC | PIN_INC;
                    seq_phase = SQ_FS_PULSE;
                end
                SQ_FS_PULSE:
                    stepping_half(fine_pos, fine_goal, PIN_CSC, 1'b0, w);
                SQ_STEP_CLOSE:
                begin
                    w = desel | PIN_INC;
                    seq_phase = pick_next_run();
                end
                SQ_FINAL:
                begin
                    w = desel | PIN_INC;
                    res.last_word = 1'b1;
                    seq_phase = SQ_IDLE;
                end
                default:
                    res.emit = 1'b0;
            endcase
            res.pin_word = w;
        end
    endtask

    // target near the current wiper, now and then an extreme or above the top
    function automatic logic [POS_W-1:0] pick_target(input logic [POS_W-1:0] now);
        int t;
        if ($urandom_range(0, 99) < 6)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return TOP_POSITION;
                2: return '1;
                default: return POS_W'($urandom_range(0, 127));
            endcase
        end
        t = int'(now) + int'($urandom_range(0, 6)) - 3;
        if (t < 0)
            t = 0;
        if (t > int'(TOP_POSITION))
            t = int'(TOP_POSITION);
        return t[POS_W-1:0];
    endfunction

    function automatic item_t random_move();
        item_t it;
        it.opcode = OP_MOVE;
        it.coarse_target = pick_target(coarse_pos);
        it.fine_target = pick_target(fine_pos);
        it.pins_now = PIN_W'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic item_t random_tick();
        item_t it;
        it.opcode = OP_TICK;
        it.coarse_target = POS_W'($urandom_range(0, 127));
        it.fine_target = POS_W'($urandom_range(0, 127));
        it.pins_now = PIN_W'($urandom_range(0, 255));
        return it;
    endfunction

    // one input transfer, then the prediction and an optional gap
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        result_t res;
        int      gap;
        in_valid <= 1'b1;
        opcode <= it.opcode;
        coarse_target <= it.coarse_target;
        fine_target <= it.fine_target;
        pins_now <= it.pins_now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pin_word(it, res);
        if (typed)
            res = want;
        if (res.emit)
            expected_words.insert(expected_words.size(), res);
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // output side: check each transfer, stall at random
    always @(posedge clk)
    begin : watch_outputs
        result_t exp_res;
        if (rst_n === 1'b1 && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("pin_word with nothing expected: actual %h last_word %b",
                       pin_word, last_word);
                mismatches++;
            end
            else
            begin
                exp_res = expected_words.pop_front();
                if (pin_word !== exp_res.pin_word)
                begin
                    $error("pin_word expected %h actual %h", exp_res.pin_word, pin_word);
                    mismatches++;
                end
                if (last_word !== exp_res.last_word)
                begin
                    $error("last_word expected %b actual %b", exp_res.last_word, last_word);
                    mismatches++;
                end
            end
        end
        if (ready_hold > 0)
            ready_hold--;
        else if (!steady)
            ready_hold = idle_len();
        out_ready <= (ready_hold == 0);
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("FAIL dual_pot_wiper_sequencer");
        $finish;
    end

    initial
    begin : stimulus
        int    counted;
        bit    counts;
        item_t it;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        opcode <= OP_TICK;
        coarse_target <= '0;
        fine_target <= '0;
        pins_now <= '0;
        coarse_pos = '0;
        fine_pos = '0;
        coarse_goal = '0;
        fine_goal = '0;
        pulse_cnt = '0;
        coarse_known = 1'b0;
        fine_known = 1'b0;
        half_done = 1'b0;
        base_pins = '0;
        seq_phase = SQ_IDLE;
        counted = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle tick, clamped move, dropped commands, preamble, homing start
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_table[i].stim, dir_table[i].typed, dir_table[i].want);

        // run out the homing sequence of the first move
        while (seq_phase != SQ_IDLE)
            send_item(random_tick(), 1'b0, '0);

        // random moves with ticks, idle ticks and commands while busy as noise
        while (counted < RANDOM_ITEMS)
        begin
            if (seq_phase == SQ_IDLE)
            begin
                counts = steady || ($urandom_range(0, 9) != 0);
                it = counts ? random_move() : random_tick();
            end
            else
            begin
                counts = ($urandom_range(0, 19) != 0);
                it = counts ? random_tick() : random_move();
            end
            send_item(it, 1'b0, '0);
            if (counts)
            begin
                counted++;
                if (counted % STEADY_SPAN == 0)
                    steady = !steady;
            end
        end
        in_valid <= 1'b0;

        // drain outstanding words, then allow for the pipeline
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASS dual_pot_wiper_sequencer");
        else
            $display("FAIL dual_pot_wiper_sequencer");
        $finish;
    end

endmodule

// ===== sim.f =====
src/dpws_pkg.sv
src/dpws_seq.sv
src/dual_pot_wiper_sequencer.sv
verif/tb.sv
